@@ design/dtcw_pkg.sv @@
// Shared types and constants of the decimal text cell writer.
package dtcw_pkg;

   localparam int unsigned MAX_DIGITS = 10;
   localparam int unsigned DIGIT_IDX_W = $clog2(MAX_DIGITS);
   localparam int unsigned DIGIT_CNT_W = $clog2(MAX_DIGITS + 1);

   // floor(v * RECIP_TEN / 2^35) == v / 10 for every 32-bit v
   localparam logic [31:0] RECIP_TEN = 32'hCCCC_CCCD;
   localparam int unsigned RECIP_SHIFT = 35;

   localparam logic [7:0] ASCII_ZERO = 8'h30;

   localparam logic [7:0] COLS_RESET = 8'd80;
   localparam logic [7:0] ROWS_RESET = 8'd25;
   localparam logic [7:0] ATTR_RESET = 8'h0F;

   typedef enum logic [1:0] {
      CSR_SCREEN_COLUMNS = 2'd0,
      CSR_SCREEN_ROWS    = 2'd1,
      CSR_TEXT_ATTRIBUTE = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [7:0]  column;
      logic [7:0]  row;
      logic [31:0] value;
   } req_type;

   typedef struct packed {
      logic [15:0] cell_index;
      logic [15:0] cell_word;
      logic        last_digit;
   } rsp_type;

   // one classified, on-screen number waiting for conversion
   typedef struct packed {
      logic [15:0] base;
      logic [31:0] value;
   } job_type;

   typedef struct packed {
      logic    push;
      job_type job;
   } push_type;

   typedef struct packed {
      logic    empty;
      logic    full;
      job_type head;
   } queue_status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIG,
      ST_EMIT
   } back_state_type;

endpackage

@@ design/decimal_text_cell_writer.sv @@
// Top level of the decimal text cell writer: config registers, front, queue, back.
//
//  channel   direction  ports                               transaction
//  request   in         start, busy, req_data               start && !busy
//  response  out        rsp_valid, rsp_data                 rsp_valid (one cycle)
//  csr       in         csr_wr_en, csr_index, csr_wdata     csr_wr_en
//
// A number is taken in the cycle it is offered unless the job queue is full.
// Off-screen positions are dropped at the front end and produce nothing.
// Conversion has a load step, then per digit one 32x32 reciprocal multiply
// and the remainder step; the writes then leave one per cycle, most
// significant digit first. The front keeps accepting while the back end
// works, as long as the queue has room.
// Reset is synchronous and empties the queue and idles the engine.
// The receiver cannot stall, so each write shows for exactly one cycle.
module decimal_text_cell_writer #(
   parameter int unsigned QUEUE_DEPTH = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  dtcw_pkg::req_type req_data,
   output logic              rsp_valid,
   output dtcw_pkg::rsp_type rsp_data,
   input  logic              csr_wr_en,
   input  logic [1:0]        csr_index,
   input  logic [7:0]        csr_wdata
);

   logic [7:0] cols_ff, cols_in;
   logic [7:0] rows_ff, rows_in;
   logic [7:0] attr_ff, attr_in;

   dtcw_pkg::push_type         push;
   dtcw_pkg::queue_status_type queue_status;
   logic                       pop;

   // register file; index three is ignored
   always_comb begin
      cols_in = cols_ff;
      rows_in = rows_ff;
      attr_in = attr_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            dtcw_pkg::CSR_SCREEN_COLUMNS: cols_in = csr_wdata;
            dtcw_pkg::CSR_SCREEN_ROWS:    rows_in = csr_wdata;
            dtcw_pkg::CSR_TEXT_ATTRIBUTE: attr_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff <= dtcw_pkg::COLS_RESET;
         rows_ff <= dtcw_pkg::ROWS_RESET;
         attr_ff <= dtcw_pkg::ATTR_RESET;
      end else begin
         cols_ff <= cols_in;
         rows_ff <= rows_in;
         attr_ff <= attr_in;
      end
   end

   // busy only when there is no room for another job
   assign busy = queue_status.full;

   dtcw_front u_front (
      .start          (start),
      .queue_full     (queue_status.full),
      .req_data       (req_data),
      .screen_columns (cols_ff),
      .screen_rows    (rows_ff),
      .push_out       (push)
   );

   dtcw_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push_in (push),
      .pop     (pop),
      .status  (queue_status)
   );

   dtcw_back u_back (
      .clock          (clock),
      .reset          (reset),
      .queue_status   (queue_status),
      .text_attribute (attr_ff),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_data       (rsp_data)
   );

endmodule

@@ design/dtcw_front.sv @@
// Front end: accepts numbers, drops off-screen ones, computes the base cell index.
module dtcw_front (
   input  logic              start,
   input  logic              queue_full,
   input  dtcw_pkg::req_type req_data,
   input  logic [7:0]        screen_columns,
   input  logic [7:0]        screen_rows,
   output dtcw_pkg::push_type push_out
);

   logic        accept;
   logic        on_screen;
   logic [15:0] row_offset;

   assign accept     = start && !queue_full;
   assign on_screen  = (req_data.column < screen_columns) && (req_data.row < screen_rows);
   assign row_offset = 16'(req_data.row) * 16'(screen_columns);

   always_comb begin
      push_out.push      = accept && on_screen;
      push_out.job.base  = row_offset + 16'(req_data.column);
      push_out.job.value = req_data.value;
   end

endmodule

@@ design/dtcw_queue.sv @@
// Small job queue between the front end and the conversion engine.
module dtcw_queue #(
   parameter int unsigned DEPTH = 2
) (
   input  logic                       clock,
   input  logic                       reset,
   input  dtcw_pkg::push_type         push_in,
   input  logic                       pop,
   output dtcw_pkg::queue_status_type status
);

   localparam int unsigned AW = $clog2(DEPTH);
   localparam int unsigned CW = $clog2(DEPTH + 1);

   dtcw_pkg::job_type entries_ff [DEPTH];
   logic [AW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]     count_ff, count_in;
   logic              do_pop;

   assign do_pop = pop && (count_ff != '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_in.push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_in.push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !push_in.push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_in.push) begin
         entries_ff[wr_ptr_ff] <= push_in.job;
      end
   end

   always_comb begin
      status.empty = (count_ff == '0);
      status.full  = (count_ff == CW'(DEPTH));
      status.head  = entries_ff[rd_ptr_ff];
   end

   // front must never push into a full queue
   assert property (@(posedge clock) disable iff (reset)
      push_in.push |-> (count_ff != CW'(DEPTH)) || do_pop)
      else $error("dtcw_queue: push while full");

endmodule

@@ design/dtcw_back.sv @@
// Back end: divides by ten one digit at a time, then streams cell writes MSB first.
module dtcw_back (
   input  logic                       clock,
   input  logic                       reset,
   input  dtcw_pkg::queue_status_type queue_status,
   input  logic [7:0]                 text_attribute,
   output logic                       pop,
   output logic                       rsp_valid,
   output dtcw_pkg::rsp_type          rsp_data
);

   localparam int unsigned IW = dtcw_pkg::DIGIT_IDX_W;
   localparam int unsigned CW = dtcw_pkg::DIGIT_CNT_W;

   dtcw_pkg::back_state_type state_ff, state_in;

   logic [31:0]       value_ff, value_in;
   logic [15:0]       base_ff, base_in;
   logic [63:0]       prod_ff, prod_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic [IW-1:0]     ptr_ff, ptr_in;
   logic [IW-1:0]     off_ff, off_in;
   logic [3:0]        digits_ff [dtcw_pkg::MAX_DIGITS];
   logic              digit_we;
   logic [28:0]       quot;
   logic [3:0]        digit;
   logic              rsp_valid_ff, rsp_valid_in;
   dtcw_pkg::rsp_type rsp_data_ff, rsp_data_in;

   assign quot  = prod_ff[63:dtcw_pkg::RECIP_SHIFT];
   // remainder fits in four bits, so only the low bits of v - 10q matter
   assign digit = value_ff[3:0] - {quot[2:0], 1'b0} - {quot[0], 3'b000};

   always_comb begin
      state_in     = state_ff;
      value_in     = value_ff;
      base_in      = base_ff;
      prod_in      = prod_ff;
      cnt_in       = cnt_ff;
      ptr_in       = ptr_ff;
      off_in       = off_ff;
      digit_we     = 1'b0;
      pop          = 1'b0;
      rsp_valid_in = 1'b0;
      rsp_data_in.cell_index = base_ff + 16'(off_ff);
      rsp_data_in.cell_word  = {text_attribute,
                                dtcw_pkg::ASCII_ZERO | {4'b0000, digits_ff[ptr_ff]}};
      rsp_data_in.last_digit = (ptr_ff == '0);
      unique case (state_ff)
         dtcw_pkg::ST_IDLE: begin
            if (!queue_status.empty) begin
               pop      = 1'b1;
               value_in = queue_status.head.value;
               base_in  = queue_status.head.base;
               cnt_in   = '0;
               state_in = dtcw_pkg::ST_MUL;
            end
         end
         dtcw_pkg::ST_MUL: begin
            prod_in  = 64'(value_ff) * 64'(dtcw_pkg::RECIP_TEN);
            state_in = dtcw_pkg::ST_DIG;
         end
         dtcw_pkg::ST_DIG: begin
            digit_we = 1'b1;
            cnt_in   = cnt_ff + 1'b1;
            value_in = {3'b000, quot};
            if (quot == '0) begin
               ptr_in   = cnt_ff[IW-1:0];
               off_in   = '0;
               state_in = dtcw_pkg::ST_EMIT;
            end else begin
               state_in = dtcw_pkg::ST_MUL;
            end
         end
         dtcw_pkg::ST_EMIT: begin
            rsp_valid_in = 1'b1;
            ptr_in       = ptr_ff - 1'b1;
            off_in       = off_ff + 1'b1;
            if (ptr_ff == '0) begin
               state_in = dtcw_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = dtcw_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dtcw_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff    <= value_in;
      base_ff     <= base_in;
      prod_ff     <= prod_in;
      cnt_ff      <= cnt_in;
      ptr_ff      <= ptr_in;
      off_ff      <= off_in;
      rsp_data_ff <= rsp_data_in;
      if (digit_we) begin
         digits_ff[cnt_ff[IW-1:0]] <= digit;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // a strobe only ever follows an output cycle of the engine
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(state_ff) == dtcw_pkg::ST_EMIT)
      else $error("dtcw_back: strobe outside emit");

   // every digit step is preceded by its multiply
   assert property (@(posedge clock) disable iff (reset)
      state_ff == dtcw_pkg::ST_DIG |-> $past(state_ff) == dtcw_pkg::ST_MUL)
      else $error("dtcw_back: digit step without multiply");

   // a 32-bit value never needs more than ten digits
   assert property (@(posedge clock) disable iff (reset)
      state_ff == dtcw_pkg::ST_DIG |-> cnt_ff < CW'(dtcw_pkg::MAX_DIGITS))
      else $error("dtcw_back: digit count overflow");

   // the marked write closes the number and returns the engine to idle
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.last_digit |-> state_ff == dtcw_pkg::ST_IDLE)
      else $error("dtcw_back: last write without return to idle");

endmodule

@@ verif/tb_decimal_text_cell_writer.sv @@
// Testbench for decimal_text_cell_writer: directed table plus random phases, self-checking.
`timescale 1ns / 100ps

module tb_decimal_text_cell_writer;

   // Run bounds. SETTLE_CYCLES covers a job that may still be in flight after
   // the last expected write has been seen.
   localparam int unsigned CYCLE_LIMIT   = 200000;
   localparam int unsigned SETTLE_CYCLES = 40;
   localparam int unsigned REPORT_LIMIT  = 10;
   localparam int unsigned NUM_DIGITS    = 10;
   localparam int unsigned RANDOM_PHASES = 6;
   localparam int unsigned PHASE_NUMBERS = 12;
   localparam logic [7:0]  CHAR_ZERO     = 8'h30;
   // index 3 maps to no register; writes there must be dropped
   localparam logic [1:0]  CSR_NO_SUCH_REG = 2'd3;

   typedef enum logic {STEP_REG, STEP_NUMBER} step_kind_type;
   // how a number row is checked: against the predictor, expecting nothing
   // (off screen), or against one typed-in single-digit write
   typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_ONE} check_type;

   typedef struct {
      step_kind_type kind;
      logic [1:0]    reg_index;
      logic [7:0]    reg_data;
      logic [7:0]    column;
      logic [7:0]    row;
      logic [31:0]   value;
      check_type     check;
      logic [15:0]   cell_index;
      logic [15:0]   cell_word;
   } script_step_type;

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   dtcw_pkg::req_type req_data;
   logic              rsp_valid;
   dtcw_pkg::rsp_type rsp_data;
   logic              csr_wr_en;
   logic [1:0]        csr_index;
   logic [7:0]        csr_wdata;

   decimal_text_cell_writer dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Shadow copy of the screen configuration, updated as each write lands.
   logic [7:0] cfg_columns;
   logic [7:0] cfg_rows;
   logic [7:0] cfg_attribute;

   dtcw_pkg::rsp_type expected_writes[$];
   dtcw_pkg::rsp_type wanted_write;
   int unsigned       write_errors;
   int unsigned       cycle_count;
   bit                no_gaps;        // burst mode: sender offers back to back

   script_step_type script [33];

   always #5 clock = ~clock;

   // Watchdog: a hang anywhere ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("end of test: mismatches");
         $finish;
      end
   end

   // Expected digit writes for one accepted number, pushed in output order.
   // Returns how many writes the number causes (zero when off screen).
   function automatic int unsigned predict_digit_writes(dtcw_pkg::req_type num);
      logic [3:0]        digit_buf [NUM_DIGITS];
      logic [31:0]       rest;
      logic [15:0]       base;
      int unsigned       ndig;
      dtcw_pkg::rsp_type wr_item;
      ndig = 0;
      if (num.column >= cfg_columns || num.row >= cfg_rows)
         return 0;
      // least significant digit first; zero still yields one digit
      rest = num.value;
      do begin
         digit_buf[ndig] = 4'(rest % 10);
         ndig++;
         rest = rest / 10;
      end while (rest != 0);
      // fits in 16 bits for any on-screen position; no line clipping
      base = {8'd0, num.row} * {8'd0, cfg_columns} + {8'd0, num.column};
      for (int unsigned k = 0; k < ndig; k++) begin
         wr_item.cell_index = base + 16'(k);
         wr_item.cell_word  = {cfg_attribute, CHAR_ZERO + {4'd0, digit_buf[ndig - 1 - k]}};
         wr_item.last_digit = (k == ndig - 1);
         expected_writes.push_back(wr_item);
      end
      return ndig;
   endfunction

   task automatic note_error(string what, bit has_want, dtcw_pkg::rsp_type want,
                             dtcw_pkg::rsp_type got);
      write_errors++;
      if (write_errors <= REPORT_LIMIT) begin
         if (has_want)
            $display("%0t %s: expected index %0d word %h last %0b, got index %0d word %h last %0b",
                     $realtime, what, want.cell_index, want.cell_word, want.last_digit,
                     got.cell_index, got.cell_word, got.last_digit);
         else
            $display("%0t %s: got index %0d word %h last %0b", $realtime, what,
                     got.cell_index, got.cell_word, got.last_digit);
      end
   endtask

   // Result checker. Each write is on the ports for exactly one cycle, so the
   // mid-cycle sample sees it once and never races the edge.
   always @(negedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_writes.size() == 0) begin
            note_error("cell write with nothing pending", 1'b0, rsp_data, rsp_data);
         end else begin
            wanted_write = expected_writes.pop_front();
            if (rsp_data.cell_index !== wanted_write.cell_index ||
                rsp_data.cell_word  !== wanted_write.cell_word ||
                rsp_data.last_digit !== wanted_write.last_digit)
               note_error("cell write mismatch", 1'b1, wanted_write, rsp_data);
         end
      end
   end

   // Offer one number after a random gap and hold it until the block takes it.
   // busy is sampled mid-cycle: the transaction happens at the next rising edge
   // iff busy was low there. Expectations are queued at that edge.
   task automatic send_number(dtcw_pkg::req_type num, check_type how,
                              dtcw_pkg::rsp_type typed);
      int unsigned gap;
      bit          taken;
      gap = no_gaps ? 0 : $urandom_range(0, 18);
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= num;
      do begin
         @(negedge clock);
         taken = !busy;
         @(posedge clock);
      end while (!taken);
      case (how)
         CHK_MODEL: void'(predict_digit_writes(num));
         CHK_ONE:   expected_writes.push_back(typed);
         default:   ;
      endcase
   endtask

   // Stop offering, let every expected write drain, then give any dropped or
   // in-flight job time to finish before the config may change.
   task automatic wait_idle();
      start <= 1'b0;
      while (expected_writes.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One register write per call; csr_wr_en is dropped by close_reg_writes
   // so back-to-back writes never lower and raise it in the same step.
   task automatic write_reg(logic [1:0] idx, logic [7:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         dtcw_pkg::CSR_SCREEN_COLUMNS: cfg_columns   = data;
         dtcw_pkg::CSR_SCREEN_ROWS:    cfg_rows      = data;
         dtcw_pkg::CSR_TEXT_ATTRIBUTE: cfg_attribute = data;
         default:                      ;
      endcase
   endtask

   task automatic close_reg_writes();
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   // Screen bound with the extremes drawn often.
   function automatic logic [7:0] pick_bound();
      case ($urandom_range(0, 4))
         0:       return 8'd1;
         1:       return 8'd255;
         default: return 8'($urandom_range(1, 255));
      endcase
   endfunction

   initial begin
      dtcw_pkg::req_type num;
      dtcw_pkg::rsp_type typed;
      bit                writing_regs;
      int unsigned       on_screen;
      int unsigned       ndig;
      longint unsigned   lo;
      longint unsigned   hi;

      clock         = 1'b0;
      reset         = 1'b1;
      start         = 1'b0;
      req_data      = '0;
      csr_wr_en     = 1'b0;
      csr_index     = dtcw_pkg::CSR_SCREEN_COLUMNS;
      csr_wdata     = '0;
      cfg_columns   = 8'd80;
      cfg_rows      = 8'd25;
      cfg_attribute = 8'h0F;
      write_errors  = 0;
      cycle_count   = 0;
      no_gaps       = 1'b0;
      writing_regs  = 1'b0;

      // Directed table. Index field is unused on number rows.
      script = '{
         // reset config 80x25, attribute 0x0F: zero, bottom-right corner, off-screen edges
         '{STEP_NUMBER, dtcw_pkg::CSR_SCREEN_COLUMNS, 8'd0, 8'd0,   8'd0,   32'd0,
           CHK_ONE,   16'd0,    16'h0F30},
         '{STEP_NUMBER, dtcw_pkg::CSR_SCREEN_COLUMNS, 8'd0, 8'd79,  8'd24,  32'd9,
           CHK_ONE,   16'd1999, 16'h0F39},
         '{STEP_NUMBER, dtcw_pkg::CSR_SCREEN_COLUMNS, 8'd0, 8'd80,  8'd0,   32'd5,
           CHK_NONE,  16'd0,    16'd0},
         '{STEP_NUMBER, dtcw_pkg::CSR_SCREEN_COLUMNS, 8'd0, 8'd0,   8'd25,  32'd5,
           CHK_NONE,  16'd0,    16'd0},
         '{STEP_NUMBER, dtcw_pkg::CSR_SCREEN_COLUMNS, 8'd0, 8'd255, 8'd255, 32'd1,
           CHK_NONE,  16'd0,    16'd0},
         // widest value, line overflow, long runs of zeros, two digits
         '{STEP_NUMBER, dtcw_pkg::CSR_SCREEN_COLUMNS, 8'd0, 8'd0,   8'd0,   32'hFFFF_FFFF,
           CHK_MODEL, 16'd0,    16'd0},
         '{STEP_NUMBER, dtcw_pkg::CSR_SCREEN_COLUMNS, 8'd0, 8'd75,  8'd3,   32'd1234567890,
           CHK_MODEL, 16'd0,    16'd0},
         '{STEP_NUMBER, dtcw_pkg::CSR_SCREEN_COLUMNS, 8'd0, 8'd12,  8'd7,   32'd1000000000,
           CHK_MODEL, 16'd0,    16'd0},
         '{STEP_NUMBER, dtcw_pkg::CSR_SCREEN_COLUMNS, 8'd0, 8'd1,   8'd1,   32'd10,
           CHK_MODEL, 16'd0,    16'd0},
         // write to a nonexistent register: nothing may change
         '{STEP_REG,    CSR_NO_SUCH_REG,              8'd0, 8'd0,   8'd0,   32'd0,
           CHK_NONE,  16'd0,    16'd0},
         '{STEP_NUMBER, dtcw_pkg::CSR_SCREEN_COLUMNS, 8'd0, 8'd0,   8'd0,   32'd4,
           CHK_ONE,   16'd0,    16'h0F34},
         // largest screen, attribute all ones
         '{STEP_REG,    dtcw_pkg::CSR_SCREEN_COLUMNS, 8'd255, 8'd0, 8'd0,   32'd0,
           CHK_NONE,  16'd0,    16'd0},
         '{STEP_REG,    dtcw_pkg::CSR_SCREEN_ROWS,    8'd255, 8'd0, 8'd0,   32'd0,
           CHK_NONE,  16'd0,    16'd0},
         '{STEP_REG,    dtcw_pkg::CSR_TEXT_ATTRIBUTE, 8'hFF,  8'd0, 8'd0,   32'd0,
           CHK_NONE,  16'd0,    16'd0},
         '{STEP_NUMBER, dtcw_pkg::CSR_SCREEN_COLUMNS, 8'd0, 8'd254, 8'd254, 32'hFFFF_FFFF,
           CHK_MODEL, 16'd0,    16'd0},
         '{STEP_NUMBER, dtcw_pkg::CSR_SCREEN_COLUMNS, 8'd0, 8'd255, 8'd0,   32'd7,
           CHK_NONE,  16'd0,    16'd0},
         '{STEP_NUMBER, dtcw_pkg::CSR_SCREEN_COLUMNS, 8'd0, 8'd0,   8'd255, 32'd7,
           CHK_NONE,  16'd0,    16'd0},
         // single-cell screen, attribute zero
         '{STEP_REG,    dtcw_pkg::CSR_SCREEN_COLUMNS, 8'd1, 8'd0,   8'd0,   32'd0,
           CHK_NONE,  16'd0,    16'd0},
         '{STEP_REG,    dtcw_pkg::CSR_SCREEN_ROWS,    8'd1, 8'd0,   8'd0,   32'd0,
           CHK_NONE,  16'd0,    16'd0},
         '{STEP_REG,    dtcw_pkg::CSR_TEXT_ATTRIBUTE, 8'h00, 8'd0,  8'd0,   32'd0,
           CHK_NONE,  16'd0,    16'd0},
         '{STEP_NUMBER, dtcw_pkg::CSR_SCREEN_COLUMNS, 8'd0, 8'd0,   8'd0,   32'd0,
           CHK_ONE,   16'd0,    16'h0030},
         '{STEP_NUMBER, dtcw_pkg::CSR_SCREEN_COLUMNS, 8'd0, 8'd1,   8'd0,   32'd3,
           CHK_NONE,  16'd0,    16'd0},
         '{STEP_NUMBER, dtcw_pkg::CSR_SCREEN_COLUMNS, 8'd0, 8'd0,   8'd0,   32'd99,
           CHK_MODEL, 16'd0,    16'd0},
         // zero width: every position is off screen
         '{STEP_REG,    dtcw_pkg::CSR_SCREEN_COLUMNS, 8'd0, 8'd0,   8'd0,   32'd0,
           CHK_NONE,  16'd0,    16'd0},
         '{STEP_NUMBER, dtcw_pkg::CSR_SCREEN_COLUMNS, 8'd0, 8'd0,   8'd0,   32'd1,
           CHK_NONE,  16'd0,    16'd0},
         // zero height
         '{STEP_REG,    dtcw_pkg::CSR_SCREEN_COLUMNS, 8'd40, 8'd0,  8'd0,   32'd0,
           CHK_NONE,  16'd0,    16'd0},
         '{STEP_REG,    dtcw_pkg::CSR_SCREEN_ROWS,    8'd0, 8'd0,   8'd0,   32'd0,
           CHK_NONE,  16'd0,    16'd0},
         '{STEP_NUMBER, dtcw_pkg::CSR_SCREEN_COLUMNS, 8'd0, 8'd0,   8'd0,   32'd1,
           CHK_NONE,  16'd0,    16'd0},
         // 40x12 screen: last cell on, one past in each direction off
         '{STEP_REG,    dtcw_pkg::CSR_SCREEN_ROWS,    8'd12, 8'd0,  8'd0,   32'd0,
           CHK_NONE,  16'd0,    16'd0},
         '{STEP_REG,    dtcw_pkg::CSR_TEXT_ATTRIBUTE, 8'h5A, 8'd0,  8'd0,   32'd0,
           CHK_NONE,  16'd0,    16'd0},
         '{STEP_NUMBER, dtcw_pkg::CSR_SCREEN_COLUMNS, 8'd0, 8'd39,  8'd11,  32'd123,
           CHK_MODEL, 16'd0,    16'd0},
         '{STEP_NUMBER, dtcw_pkg::CSR_SCREEN_COLUMNS, 8'd0, 8'd40,  8'd11,  32'd123,
           CHK_NONE,  16'd0,    16'd0},
         '{STEP_NUMBER, dtcw_pkg::CSR_SCREEN_COLUMNS, 8'd0, 8'd39,  8'd12,  32'd123,
           CHK_NONE,  16'd0,    16'd0}
      };

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // ---- directed part ----
      foreach (script[i]) begin
         if (script[i].kind == STEP_REG) begin
            if (!writing_regs)
               wait_idle();
            writing_regs = 1'b1;
            write_reg(script[i].reg_index, script[i].reg_data);
         end else begin
            if (writing_regs)
               close_reg_writes();
            writing_regs = 1'b0;
            num.column       = script[i].column;
            num.row          = script[i].row;
            num.value        = script[i].value;
            typed.cell_index = script[i].cell_index;
            typed.cell_word  = script[i].cell_word;
            typed.last_digit = 1'b1;
            send_number(num, script[i].check, typed);
         end
      end

      // ---- random phases: new config, then a batch of numbers ----
      typed = '0;
      for (int unsigned phase = 0; phase < RANDOM_PHASES; phase++) begin
         wait_idle();
         if ($urandom_range(0, 2) == 0)
            write_reg(CSR_NO_SUCH_REG, 8'($urandom_range(0, 255)));
         write_reg(dtcw_pkg::CSR_SCREEN_COLUMNS, pick_bound());
         write_reg(dtcw_pkg::CSR_SCREEN_ROWS, pick_bound());
         write_reg(dtcw_pkg::CSR_TEXT_ATTRIBUTE, 8'($urandom_range(0, 255)));
         close_reg_writes();
         // every third phase runs back to back with no sender gaps
         no_gaps = (phase % 3 == 1);
         on_screen = 0;
         while (on_screen < PHASE_NUMBERS) begin
            // mostly on-screen positions; the rest is anywhere in the field range
            if ($urandom_range(0, 4) != 0) begin
               num.column = 8'($urandom_range(0, cfg_columns - 1));
               num.row    = 8'($urandom_range(0, cfg_rows - 1));
            end else begin
               num.column = 8'($urandom_range(0, 255));
               num.row    = 8'($urandom_range(0, 255));
            end
            // spread over digit counts; now and then a raw 32-bit draw
            if ($urandom_range(0, 9) == 0) begin
               num.value = $urandom();
            end else begin
               ndig = $urandom_range(1, NUM_DIGITS);
               lo   = (ndig == 1) ? 64'd0 : 64'd10 ** (ndig - 1);
               hi   = 64'd10 ** ndig - 1;
               if (hi > 64'hFFFF_FFFF)
                  hi = 64'hFFFF_FFFF;
               num.value = 32'(lo + ({$urandom(), $urandom()} % (hi - lo + 1)));
            end
            if (num.column < cfg_columns && num.row < cfg_rows)
               on_screen++;
            send_number(num, CHK_MODEL, typed);
         end
      end

      wait_idle();
      if (write_errors == 0 && expected_writes.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
design/dtcw_pkg.sv
design/dtcw_front.sv
design/dtcw_queue.sv
design/dtcw_back.sv
design/decimal_text_cell_writer.sv
verif/tb_decimal_text_cell_writer.sv
